// ----- src/fmo_pkg.sv -----
// Shared types, constants and the quarter-wave sine table for the FM oscillator.
// No dependencies; used by fmo_front, fmo_back and fm_sine_oscillator.
package fmo_pkg;

   localparam int PHASE_BITS = 32;
   localparam int TABLE_BITS = 10;
   localparam int OUT_BITS   = 16;

   localparam int FREQ_BITS   = 24;
   localparam int FM_BITS     = 16;
   localparam int DEPTH_BITS  = 24;
   localparam int TPH_BITS    = 28;
   localparam int FMPROD_BITS = FM_BITS + DEPTH_BITS;
   localparam int FM_SHIFT    = 15;
   localparam int FMQ_BITS    = FMPROD_BITS - FM_SHIFT;
   localparam int SUM_BITS    = FREQ_BITS + 2;
   localparam int STEP_BITS   = FREQ_BITS + TPH_BITS + 1;
   // Q16.8 times 2^40/fs puts one turn at bit 48
   localparam int STEP_POINT  = 48;

   localparam int QSTEPS    = 1 << (TABLE_BITS - 2);
   localparam int QIDX_BITS = TABLE_BITS - 1;
   localparam int MAG_BITS  = OUT_BITS - 1;

   localparam logic [TPH_BITS-1:0] TPH_RESET = TPH_BITS'(22906492);

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_TURNS_PER_HZ = 1'b0;

   localparam logic signed [FREQ_BITS-1:0] SUM_MAX = {1'b0, {(FREQ_BITS-1){1'b1}}};
   localparam logic signed [FREQ_BITS-1:0] SUM_MIN = {1'b1, {(FREQ_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [FREQ_BITS-1:0]  freq_hz;
      logic                         reset_phase;
      logic signed [FM_BITS-1:0]    fm_sample;
      logic signed [DEPTH_BITS-1:0] fm_depth_hz;
   } fmo_item_type;

   typedef struct packed {
      logic         valid;
      fmo_item_type item;
   } fmo_handoff_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_ADV
   } fmo_state_type;

   typedef logic [MAG_BITS-1:0] qtab_type [0:QSTEPS];

   // Polynomial sine in unsigned Q30, evaluated at elaboration only
   function automatic qtab_type build_quarter_tab();
      qtab_type    tab;
      logic [63:0] one;
      logic [63:0] amp;
      logic [63:0] theta;
      logic [63:0] t2;
      logic [63:0] c;
      logic [63:0] s;
      one = 64'd1 << 30;
      amp = (64'd1 << (OUT_BITS - 1)) - 64'd1;
      for (int i = 0; i <= QSTEPS; i++) begin
         theta = (64'(i) * 64'd1686629713 + 64'(QSTEPS / 2)) / QSTEPS;
         t2 = (theta * theta) >> 30;
         c = one - t2 / 156;
         c = one - ((t2 * c) >> 30) / 110;
         c = one - ((t2 * c) >> 30) / 72;
         c = one - ((t2 * c) >> 30) / 42;
         c = one - ((t2 * c) >> 30) / 20;
         c = one - ((t2 * c) >> 30) / 6;
         s = (theta * c) >> 30;
         if (s > one) begin
            s = one;
         end
         tab[i] = MAG_BITS'((s * amp + (64'd1 << 29)) >> 30);
      end
      return tab;
   endfunction

   localparam qtab_type QUARTER_TAB = build_quarter_tab();

endpackage

// ----- src/fmo_front.sv -----
// Front end of the FM oscillator: two-entry item queue ahead of the sequencer.
// Depends on fmo_pkg for the item and handoff types.
module fmo_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  fmo_pkg::fmo_item_type item,
   output fmo_pkg::fmo_handoff_type head,
   input  logic                  pop
);
   import fmo_pkg::*;

   fmo_item_type slot_ff [0:1];
   fmo_item_type slot_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != 2'd0);

   always_comb begin
      slot_in   = item;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   // occupancy never exceeds the two slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("front queue count out of range");

   // pointers agree with occupancy: equal exactly when empty or full
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) == (count_ff == 2'd0 || count_ff == 2'd2))
      else $error("front queue pointers disagree with count");

endmodule

// ----- src/fmo_back.sv -----
// Back end of the FM oscillator: phase accumulator, sine lookup, FM arithmetic
// sequencer and the result register. Depends on fmo_pkg.
module fmo_back (
   input  logic                        clock,
   input  logic                        reset,
   input  fmo_pkg::fmo_handoff_type    head,
   output logic                        pop,
   input  logic [fmo_pkg::TPH_BITS-1:0] turns_per_hz,
   output logic                        out_valid,
   output logic signed [fmo_pkg::OUT_BITS-1:0] sine_out,
   input  logic                        out_pop
);
   import fmo_pkg::*;

   fmo_state_type                 state_ff, state_in;
   logic [PHASE_BITS-1:0]         phase_ff, phase_in;
   logic                          out_valid_ff, out_valid_in;
   logic signed [OUT_BITS-1:0]    sine_ff, sine_in;
   logic signed [FMPROD_BITS-1:0] fm_prod_ff, fm_prod_in;
   logic signed [FREQ_BITS-1:0]   freq_ff, freq_in;
   logic signed [STEP_BITS-1:0]   step_prod_ff, step_prod_in;

   logic                          start;
   logic [PHASE_BITS-1:0]         phase_used;
   logic [TABLE_BITS-1:0]         tab_idx;
   logic [1:0]                    quad;
   logic [QIDX_BITS-1:0]          k;
   logic [QIDX_BITS-1:0]          tab_addr;
   logic [MAG_BITS-1:0]           mag;
   logic signed [OUT_BITS-1:0]    mag_s;
   logic signed [FMQ_BITS-1:0]    fm_q;
   logic signed [SUM_BITS-1:0]    sum_wide;
   logic signed [FREQ_BITS-1:0]   sum_sat;

   always_comb begin
      start = (state_ff == ST_IDLE) && head.valid && (!out_valid_ff || out_pop);

      // sine of the phase before the advance, after an optional phase clear
      phase_used = head.item.reset_phase ? '0 : phase_ff;
      tab_idx    = phase_used[PHASE_BITS-1 -: TABLE_BITS];
      quad       = tab_idx[TABLE_BITS-1 -: 2];
      k          = {1'b0, tab_idx[TABLE_BITS-3:0]};
      tab_addr   = quad[0] ? (QIDX_BITS'(QSTEPS) - k) : k;
      mag        = QUARTER_TAB[tab_addr];
      mag_s      = $signed({1'b0, mag});

      // Q16.8 FM term, floor shift, then saturated sum
      fm_q     = fm_prod_ff[FMPROD_BITS-1:FM_SHIFT];
      sum_wide = SUM_BITS'(freq_ff) + SUM_BITS'(fm_q);
      if (sum_wide > SUM_BITS'(SUM_MAX)) begin
         sum_sat = SUM_MAX;
      end else if (sum_wide < SUM_BITS'(SUM_MIN)) begin
         sum_sat = SUM_MIN;
      end else begin
         sum_sat = sum_wide[FREQ_BITS-1:0];
      end

      state_in     = state_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff && !out_pop;
      sine_in      = sine_ff;
      fm_prod_in   = fm_prod_ff;
      freq_in      = freq_ff;
      step_prod_in = step_prod_ff;
      pop          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pop          = 1'b1;
               phase_in     = phase_used;
               sine_in      = quad[1] ? -mag_s : mag_s;
               out_valid_in = 1'b1;
               fm_prod_in   = head.item.fm_sample * head.item.fm_depth_hz;
               freq_in      = head.item.freq_hz;
               state_in     = ST_SUM;
            end
         end
         ST_SUM: begin
            step_prod_in = sum_sat * $signed({1'b0, turns_per_hz});
            state_in     = ST_ADV;
         end
         ST_ADV: begin
            phase_in = phase_ff + step_prod_ff[STEP_POINT-1 -: PHASE_BITS];
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sine_ff      <= sine_in;
      fm_prod_ff   <= fm_prod_in;
      freq_ff      <= freq_in;
      step_prod_ff <= step_prod_in;
   end

   assign out_valid = out_valid_ff;
   assign sine_out  = sine_ff;

   // a started item always leaves a result waiting and moves on to the sum step
   a_start_result: assert property (@(posedge clock) disable iff (reset)
      start |=> (out_valid_ff && state_ff == ST_SUM))
      else $error("start did not load the result register");

   // a waiting result is never overwritten before it is taken
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_pop) |=> $stable(sine_ff))
      else $error("waiting result changed");

   // a phase clear request gives a zero phase until the advance
   a_phase_clear: assert property (@(posedge clock) disable iff (reset)
      (start && head.item.reset_phase) |=> (phase_ff == '0))
      else $error("phase not cleared");

   // the phase only moves on the advance step or a start
   a_phase_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |=> $stable(phase_ff))
      else $error("phase moved during the sum step");

endmodule

// ----- src/fm_sine_oscillator.sv -----
// Top level of the FM sine oscillator: configuration register, front queue
// and back-end sequencer. Depends on fmo_pkg, fmo_front and fmo_back.
//
// Usage notes
//  - Items go in on the req_ side like writing a queue: hold req_push with the
//    fields; the item is taken on an edge where req_full is low. One item per
//    audio sample.
//  - Results come out on the rsp_ side like reading a queue: while rsp_empty is
//    low, rsp_sine_out holds the oldest result; rsp_pop takes it. One result
//    per item, in order.
//  - An item taken into the front queue is read from its queue slot, and its result
//    is registered in the result slot once the back end is idle and that slot is free.
//  - The back end works on one item at a time, in the sequence of lookup/FM
//    multiply, saturate/step multiply and phase advance; it takes no new item
//    before that advance, as the next item's phase depends on it.
//  - The two-entry front queue keeps taking items while a result waits; if
//    rsp_pop stays low the result slot holds, the back end stops after its
//    current item and req_full rises once the queue is full. Nothing is lost.
//  - Reset (synchronous, active high) empties both sides, clears the phase
//    and loads turns_per_hz with its default (48 kHz).
//  - turns_per_hz is at byte address 0 of the csr_ port; write it only while
//    the block is idle. pready is always high.
module fm_sine_oscillator (
   input  logic                                    clock,
   input  logic                                    reset,
   // item channel
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic signed [fmo_pkg::FREQ_BITS-1:0]    req_freq_hz,
   input  logic                                    req_reset_phase,
   input  logic signed [fmo_pkg::FM_BITS-1:0]      req_fm_sample,
   input  logic signed [fmo_pkg::DEPTH_BITS-1:0]   req_fm_depth_hz,
   // result channel
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic signed [fmo_pkg::OUT_BITS-1:0]     rsp_sine_out,
   // configuration
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [fmo_pkg::CSR_ADDR_BITS-1:0]       csr_paddr,
   input  logic [fmo_pkg::CSR_DATA_BITS-1:0]       csr_pwdata,
   output logic [fmo_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                    csr_pready
);
   import fmo_pkg::*;

   logic [TPH_BITS-1:0] tph_ff, tph_in;
   logic                csr_wr;
   logic                sel_tph;
   fmo_item_type        req_item;
   fmo_handoff_type     head;
   logic                head_pop;
   logic                out_valid;

   // register select by word index; low byte-address bits are ignored
   assign sel_tph    = (csr_paddr[2] == REG_TURNS_PER_HZ);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tph_in = tph_ff;
      if (csr_wr && sel_tph) begin
         tph_in = csr_pwdata[TPH_BITS-1:0];
      end
      csr_prdata = sel_tph ? CSR_DATA_BITS'(tph_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tph_ff <= TPH_RESET;
      end else begin
         tph_ff <= tph_in;
      end
   end

   assign req_item.freq_hz     = req_freq_hz;
   assign req_item.reset_phase = req_reset_phase;
   assign req_item.fm_sample   = req_fm_sample;
   assign req_item.fm_depth_hz = req_fm_depth_hz;

   fmo_front u_front (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .item  (req_item),
      .head  (head),
      .pop   (head_pop)
   );

   fmo_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (head_pop),
      .turns_per_hz (tph_ff),
      .out_valid    (out_valid),
      .sine_out     (rsp_sine_out),
      .out_pop      (rsp_pop)
   );

   assign rsp_empty = !out_valid;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for fm_sine_oscillator: queue-style item and result sides, APB csr.
// Needs fmo_pkg and the oscillator RTL; carries its own phase and sine-table model.
`timescale 1ns / 1ps

module tb_top;
   import fmo_pkg::*;

   localparam real         CLK_PERIOD_NS = 2.0;
   localparam int          RESET_CYCLES  = 6;
   localparam int          DRAIN_CYCLES  = 6;     // lets the back end finish its current item
   localparam int          RUN_LIMIT_NS  = 500_000;
   localparam int          STALL_PCT     = 15;
   localparam int          CHUNK_ITEMS   = 155;
   localparam int          REG_SPARE     = 1;     // index with nothing behind it
   localparam logic [31:0] TPH_MAX       = 32'h0FFF_FFFF;
   // divisors of the Horner steps of the Q30 sine polynomial, innermost first
   localparam int unsigned HORNER_DIVS [0:5] = '{156, 110, 72, 42, 20, 6};

   // Directed items; pinned rows carry a result known without the model
   typedef struct packed {
      logic signed [FREQ_BITS-1:0]  freq;
      logic                         clear;
      logic signed [FM_BITS-1:0]    fm;
      logic signed [DEPTH_BITS-1:0] depth;
      logic                         pinned;
      logic signed [OUT_BITS-1:0]   pinned_sine;
   } stim_row_type;

   localparam int NUM_ROWS = 18;
   localparam stim_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      '{24'h000000, 1'b0, 16'h0000, 24'h000000, 1'b1, 16'h0000}, // phase is zero after reset
      '{24'h7FFFFF, 1'b0, 16'h0000, 24'h000000, 1'b0, 16'h0000}, // top base frequency
      '{24'h800000, 1'b0, 16'h0000, 24'h000000, 1'b0, 16'h0000}, // bottom base frequency
      '{24'h7FFFFF, 1'b0, 16'h7FFF, 24'h7FFFFF, 1'b0, 16'h0000}, // saturates high
      '{24'h000000, 1'b0, 16'h8000, 24'h800000, 1'b0, 16'h0000}, // product alone hits 2^23
      '{24'h800000, 1'b0, 16'h8000, 24'h7FFFFF, 1'b0, 16'h0000}, // saturates low
      '{24'h7FFFFF, 1'b0, 16'h8000, 24'h7FFFFF, 1'b0, 16'h0000}, // FM cancels base
      '{24'h12D687, 1'b1, 16'h0000, 24'h000000, 1'b1, 16'h0000}, // phase cleared
      '{24'hFFFFFF, 1'b0, 16'h0000, 24'h000000, 1'b0, 16'h0000}, // smallest negative step
      '{24'h000000, 1'b0, 16'hFFFF, 24'h000001, 1'b0, 16'h0000}, // product floors to -1
      '{24'h000000, 1'b0, 16'h0001, 24'h000001, 1'b0, 16'h0000}, // product floors to 0
      '{24'h01B800, 1'b0, 16'h0000, 24'h000000, 1'b0, 16'h0000}, // 440 Hz
      '{24'h000000, 1'b1, 16'h0000, 24'h000000, 1'b1, 16'h0000}, // phase cleared
      '{24'h555555, 1'b0, 16'h5555, 24'h555555, 1'b0, 16'h0000}, // alternating bits
      '{24'hAAAAAA, 1'b0, 16'hAAAA, 24'hAAAAAA, 1'b0, 16'h0000}, // the other pattern
      '{24'h800000, 1'b1, 16'h7FFF, 24'h800000, 1'b1, 16'h0000}, // cleared, then saturates
      '{24'h01B800, 1'b0, 16'h4000, 24'h006400, 1'b0, 16'h0000}, // half-scale FM
      '{24'hFE4800, 1'b0, 16'hC000, 24'h006400, 1'b0, 16'h0000}  // negative frequency
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_push        = 1'b0;
   logic                          req_full;
   logic signed [FREQ_BITS-1:0]   req_freq_hz     = '0;
   logic                          req_reset_phase = 1'b0;
   logic signed [FM_BITS-1:0]     req_fm_sample   = '0;
   logic signed [DEPTH_BITS-1:0]  req_fm_depth_hz = '0;
   logic                          rsp_empty;
   logic                          rsp_pop         = 1'b0;
   logic signed [OUT_BITS-1:0]    rsp_sine_out;
   logic                          csr_psel        = 1'b0;
   logic                          csr_penable     = 1'b0;
   logic                          csr_pwrite      = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      csr_paddr       = '0;
   logic [CSR_DATA_BITS-1:0]      csr_pwdata      = '0;
   logic [CSR_DATA_BITS-1:0]      csr_prdata;
   logic                          csr_pready;

   // Oscillator model state and the results it still owes
   logic [PHASE_BITS-1:0]       osc_phase = '0;
   logic [TPH_BITS-1:0]         osc_tph   = TPH_RESET;
   int                          sine_quarter [0:QSTEPS];
   logic signed [OUT_BITS-1:0]  sine_expected [$];
   int                          fail_count = 0;
   logic                        stall_on   = 1'b1;

   always #(CLK_PERIOD_NS / 2.0) clock = ~clock;

   fm_sine_oscillator dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_freq_hz     (req_freq_hz),
      .req_reset_phase (req_reset_phase),
      .req_fm_sample   (req_fm_sample),
      .req_fm_depth_hz (req_fm_depth_hz),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_sine_out    (rsp_sine_out),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // Quarter-wave table: sine polynomial in unsigned Q30, Horner form from the
   // innermost term outwards, clamped at one and scaled to full output range.
   function automatic void build_sine_quarter();
      logic [63:0] unit;
      logic [63:0] amp;
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] poly;
      logic [63:0] sine_q30;
      unit = 64'd1 << 30;
      amp  = (64'd1 << (OUT_BITS - 1)) - 64'd1;
      for (int i = 0; i <= QSTEPS; i++) begin
         ang    = (64'(i) * 64'd1686629713 + 64'(QSTEPS / 2)) / 64'(QSTEPS);
         ang_sq = (ang * ang) >> 30;
         poly   = unit;
         for (int j = 0; j < 6; j++) begin
            poly = unit - ((ang_sq * poly) >> 30) / 64'(HORNER_DIVS[j]);
         end
         sine_q30 = (ang * poly) >> 30;
         if (sine_q30 > unit) begin
            sine_q30 = unit;
         end
         sine_quarter[i] = int'((sine_q30 * amp + (64'd1 << 29)) >> 30);
      end
   endfunction

   // One audio sample: clear if asked, read the sine of the current phase,
   // then advance by the saturated, scaled frequency (wraps modulo a turn).
   function automatic logic signed [OUT_BITS-1:0] advance_oscillator(
      input logic signed [FREQ_BITS-1:0]  freq,
      input logic                         clear,
      input logic signed [FM_BITS-1:0]    fm,
      input logic signed [DEPTH_BITS-1:0] depth
   );
      logic [TABLE_BITS-1:0] tab_idx;
      logic [TABLE_BITS-3:0] k;
      int                    mag;
      longint                fm_term;
      longint                freq_sum;
      longint                tph_wide;
      longint                phase_step;
      logic signed [OUT_BITS-1:0] sine;
      if (clear) begin
         osc_phase = '0;
      end
      tab_idx = osc_phase[PHASE_BITS-1 -: TABLE_BITS];
      k       = tab_idx[TABLE_BITS-3:0];
      mag     = tab_idx[TABLE_BITS-2] ? sine_quarter[QSTEPS - int'(k)] : sine_quarter[k];
      sine    = tab_idx[TABLE_BITS-1] ? OUT_BITS'(-mag) : OUT_BITS'(mag);

      fm_term  = longint'(fm) * longint'(depth);
      freq_sum = longint'(freq) + (fm_term >>> FM_SHIFT);
      if (freq_sum > longint'(SUM_MAX)) begin
         freq_sum = longint'(SUM_MAX);
      end
      if (freq_sum < longint'(SUM_MIN)) begin
         freq_sum = longint'(SUM_MIN);
      end
      tph_wide   = longint'(osc_tph);
      phase_step = (freq_sum * tph_wide) >>> (STEP_POINT - PHASE_BITS);
      osc_phase  = osc_phase + phase_step[PHASE_BITS-1:0];
      return sine;
   endfunction

   // Offer one item, holding it until the block takes it; the model runs on
   // the accepting edge so expectations queue in acceptance order.
   task automatic send_item(
      input logic signed [FREQ_BITS-1:0]  freq,
      input logic                         clear,
      input logic signed [FM_BITS-1:0]    fm,
      input logic signed [DEPTH_BITS-1:0] depth,
      input logic                         pinned,
      input logic signed [OUT_BITS-1:0]   pinned_sine
   );
      logic signed [OUT_BITS-1:0] predicted;
      while (stall_on && $urandom_range(99) < STALL_PCT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_freq_hz     <= freq;
      req_reset_phase <= clear;
      req_fm_sample   <= fm;
      req_fm_depth_hz <= depth;
      do @(posedge clock); while (req_full);
      predicted = advance_oscillator(freq, clear, fm, depth);
      sine_expected.push_back(pinned ? pinned_sine : predicted);
   endtask

   function automatic logic signed [23:0] pick_corner();
      case ($urandom_range(3))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2:       return 24'h000000;
         default: return 24'hFFFFFF;
      endcase
   endfunction

   // Mix of full-range fields, audio-like settings that keep the sum in range,
   // and corner values.
   task automatic send_random(input int count);
      logic signed [FREQ_BITS-1:0]  freq;
      logic                         clear;
      logic signed [FM_BITS-1:0]    fm;
      logic signed [DEPTH_BITS-1:0] depth;
      for (int n = 0; n < count; n++) begin
         freq  = FREQ_BITS'($urandom);
         fm    = FM_BITS'($urandom);
         depth = DEPTH_BITS'($urandom);
         clear = ($urandom_range(15) == 0);
         case ($urandom_range(9))
            4, 5, 6, 7, 8: begin
               freq  = FREQ_BITS'($urandom_range(5_120_000));
               depth = DEPTH_BITS'($urandom_range(400_000));
               if ($urandom_range(1)) freq = -freq;
               if ($urandom_range(1)) depth = -depth;
            end
            9: begin
               freq  = pick_corner();
               depth = pick_corner();
               fm    = FM_BITS'(pick_corner() >>> 8);
            end
            default: ;
         endcase
         send_item(freq, clear, fm, depth, 1'b0, '0);
      end
   endtask

   // APB setup then access; psel is left high so accesses can run back to back
   task automatic csr_access(
      input  logic                     wr,
      input  logic [CSR_ADDR_BITS-1:0] addr,
      input  logic [CSR_DATA_BITS-1:0] wdata,
      output logic [CSR_DATA_BITS-1:0] rdata
   );
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   // Write a register by index, then read turns_per_hz back against the model
   task automatic set_register(input int index, input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] readback;
      csr_access(1'b1, CSR_ADDR_BITS'(index * 4), value, readback);
      if (index == int'(REG_TURNS_PER_HZ)) begin
         osc_tph = value[TPH_BITS-1:0];
      end
      csr_access(1'b0, CSR_ADDR_BITS'(int'(REG_TURNS_PER_HZ) * 4), '0, readback);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== CSR_DATA_BITS'(osc_tph)) begin
         $error("turns_per_hz: expected %0d, actual %0d", osc_tph, readback);
         fail_count++;
      end
   endtask

   // Stop offering items, let every owed result out, then let the back end settle
   task automatic wait_drained();
      req_push <= 1'b0;
      while (sine_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: pop at random, check each accepted result against the oldest
   // expectation. Sampling at the edge sees the values from before it.
   always @(posedge clock) begin : sine_checker
      logic signed [OUT_BITS-1:0] want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (sine_expected.size() == 0) begin
               $error("sine_out: no result expected, actual %0d", rsp_sine_out);
               fail_count++;
            end else begin
               want = sine_expected.pop_front();
               if (rsp_sine_out !== want) begin
                  $error("sine_out: expected %0d, actual %0d", want, rsp_sine_out);
                  fail_count++;
               end
            end
         end
         rsp_pop <= (stall_on && $urandom_range(99) < STALL_PCT) ? 1'b0 : 1'b1;
      end
   end

   initial begin
      build_sine_quarter();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed items under the reset value of turns_per_hz
      for (int r = 0; r < NUM_ROWS; r++) begin
         send_item(DIRECTED_ROWS[r].freq, DIRECTED_ROWS[r].clear, DIRECTED_ROWS[r].fm,
                   DIRECTED_ROWS[r].depth, DIRECTED_ROWS[r].pinned,
                   DIRECTED_ROWS[r].pinned_sine);
      end
      send_random(CHUNK_ITEMS);

      // a write to an unused index must leave the scale alone
      wait_drained();
      set_register(REG_SPARE, $urandom);
      send_random(CHUNK_ITEMS);

      wait_drained();
      set_register(int'(REG_TURNS_PER_HZ), 32'd1);
      send_random(CHUNK_ITEMS);

      // largest scale, with both sides running flat out
      wait_drained();
      stall_on <= 1'b0;
      set_register(int'(REG_TURNS_PER_HZ), TPH_MAX);
      send_random(CHUNK_ITEMS);

      // zero scale freezes the phase
      wait_drained();
      stall_on <= 1'b1;
      set_register(int'(REG_TURNS_PER_HZ), 32'd0);
      send_random(CHUNK_ITEMS);

      // upper bits beyond the register width are dropped
      wait_drained();
      set_register(int'(REG_TURNS_PER_HZ), 32'hA5A5_A5A5);
      send_random(CHUNK_ITEMS);

      wait_drained();
      set_register(int'(REG_TURNS_PER_HZ), $urandom_range(1, TPH_MAX));
      send_random(CHUNK_ITEMS);

      wait_drained();
      set_register(int'(REG_TURNS_PER_HZ), 32'(TPH_RESET));
      send_random(CHUNK_ITEMS);

      wait_drained();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
